// ===== sv/assert_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRT_ASSERT(label, clk, rst_n, prop, msg)
`define SRT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/srt_pkg.sv =====
// types and constants of the sorted reminder table
package srt_pkg;

    localparam int SRT_CAPACITY = 32;
    localparam int SRT_ENTRY_W  = 44;
    localparam int SRT_KEY_W    = 28;
    localparam int SRT_TAG_W    = 16;

    localparam logic [6:0] SRT_DAY_MAX   = 7'd31;
    localparam logic [6:0] SRT_MONTH_MAX = 7'd12;

    localparam logic [2:0] SRT_ST_STORED   = 3'd0;
    localparam logic [2:0] SRT_ST_BAD_DAY  = 3'd1;
    localparam logic [2:0] SRT_ST_BAD_MON  = 3'd2;
    localparam logic [2:0] SRT_ST_LISTED   = 3'd3;
    localparam logic [2:0] SRT_ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [15:0] message_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  out_month;
        logic [6:0]  out_day;
        logic [6:0]  out_hour;
        logic [6:0]  out_minute;
        logic [15:0] out_tag;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SH_RD,
        S_SH_CMP,
        S_WRITE,
        S_LS_RD,
        S_LS_OUT
    } t_state;

endpackage

// ===== sv/sorted_reminder_table.sv =====
// sorted reminder table: top level with insertion and listing sequencer
// error or empty-list result: item registered in idle, checked in decide, status registered
// when the output is free; an insertion moves each stored entry with a key not below the new
// one up a slot, then writes it; listing reads entries one by one via the single ram read port
// one item at a time: ready only in idle, so no new item is taken before the last one is done
// synchronous active-low reset clears the sequencer, entry count and output valid
`include "assert_macros.svh"
module sorted_reminder_table
    import srt_pkg::*;
#(
    parameter int CAPACITY = SRT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state    r_state, n_state;
    t_in_item  r_item, n_item;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SRT_ENTRY_W-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [SRT_ENTRY_W-1:0] ram_rdata;

    logic                   can_emit;
    logic [SRT_KEY_W-1:0]   new_key;
    logic [SRT_ENTRY_W-1:0] new_rec;
    logic [CW-1:0]          idx_dec;
    logic [CW-1:0]          idx_inc;
    logic [CW-1:0]          count_inc;

    srt_ram #(
        .WIDTH (SRT_ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign can_emit  = !r_out_valid || i_out_ready;
    assign new_key   = {r_item.month, r_item.day, r_item.hour, r_item.minute};
    assign new_rec   = {new_key, r_item.message_tag};
    assign idx_dec   = r_idx - 1'b1;
    assign idx_inc   = r_idx + 1'b1;
    assign count_inc = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = new_rec;
        ram_re      = 1'b0;
        ram_raddr   = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_item.month == '0 || r_item.day == '0) begin
                    if (r_count == '0) begin
                        if (can_emit) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.status = SRT_ST_EMPTY;
                            n_out.last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = S_LS_RD;
                    end
                end else if (r_item.day > SRT_DAY_MAX) begin
                    if (can_emit) begin
                        n_out_valid  = 1'b1;
                        n_out        = '0;
                        n_out.status = SRT_ST_BAD_DAY;
                        n_out.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (r_item.month > SRT_MONTH_MAX) begin
                    if (can_emit) begin
                        n_out_valid  = 1'b1;
                        n_out        = '0;
                        n_out.status = SRT_ST_BAD_MON;
                        n_out.last   = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx   = r_count;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (r_idx == '0) begin
                    n_state = S_WRITE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                    n_state   = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                // shift entries whose key is not below the new key one slot up
                if (ram_rdata[SRT_ENTRY_W-1:SRT_TAG_W] >= new_key) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_idx     = idx_dec;
                    n_state   = S_SH_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (can_emit) begin
                    ram_we       = 1'b1;
                    n_count      = count_inc;
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.status = SRT_ST_STORED;
                    if (count_inc == CW'(CAPACITY)) begin
                        n_out.last = 1'b0;
                        n_idx      = '0;
                        n_state    = S_LS_RD;
                    end else begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_LS_RD: begin
                ram_re  = 1'b1;
                n_state = S_LS_OUT;
            end
            S_LS_OUT: begin
                if (can_emit) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = SRT_ST_LISTED;
                    n_out.out_month  = ram_rdata[43:37];
                    n_out.out_day    = ram_rdata[36:30];
                    n_out.out_hour   = ram_rdata[29:23];
                    n_out.out_minute = ram_rdata[22:16];
                    n_out.out_tag    = ram_rdata[15:0];
                    n_out.last       = (idx_inc == r_count);
                    if (idx_inc == r_count) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_LS_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SRT_NEVER(a_count_below_cap, i_clk, i_rst_n, (r_state == S_IDLE) && (r_count >= CW'(CAPACITY)), "table not flushed when full")
    `SRT_ASSERT(a_count_step, i_clk, i_rst_n, (r_count != $past(r_count)) |-> (r_count == '0 || r_count == $past(r_count) + 1'b1), "entry count jumped")
    `SRT_NEVER(a_shift_idx, i_clk, i_rst_n, (r_state == S_SH_RD || r_state == S_SH_CMP || r_state == S_WRITE) && (r_idx > r_count), "shift index past count")
    `SRT_NEVER(a_list_idx, i_clk, i_rst_n, (r_state == S_LS_RD || r_state == S_LS_OUT) && (r_idx >= r_count), "list index past count")

endmodule

// ===== sv/srt_ram.sv =====
// generic single write, single read ram with registered read data
module srt_ram
    import srt_pkg::*;
#(
    parameter int WIDTH = SRT_ENTRY_W,
    parameter int DEPTH = SRT_CAPACITY,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
